>>> sv/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

  localparam int DEF_PAGES        = 16384;
  localparam int DEF_MAP_WORD     = 64;

  // register values after reset
  localparam int CFG_TOTAL_RST    = 16384;
  localparam int CFG_RESERVED_RST = 1;

  localparam int CMD_W   = 2;
  localparam int PAGE_W  = 14;
  localparam int COUNT_W = 15;

  localparam logic [CMD_W-1:0] CMD_INIT      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC_RUN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PAGE_W-1:0]  page_index;
    logic [COUNT_W-1:0] run_length;
  } cmd_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  start_page;
    logic               success;
    logic [COUNT_W-1:0] used_count;
  } res_t;

endpackage

>>> sv/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
  parameter int WIDTH = bpa_pkg::DEF_MAP_WORD,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bpa_engine.sv
`timescale 1ns / 1ps

module bpa_engine #(
  parameter int PAGES    = bpa_pkg::DEF_PAGES,
  parameter int MAP_WORD = bpa_pkg::DEF_MAP_WORD
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  bpa_pkg::cmd_t                 cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bpa_pkg::res_t                 res,
  input  logic [$clog2(PAGES+1)-1:0]    eff_total,
  input  logic [$clog2(PAGES+1)-1:0]    eff_reserved
);

  import bpa_pkg::*;

  localparam int LW    = $clog2(MAP_WORD);
  localparam int SW    = LW + 1;
  localparam int WORDS = (PAGES + MAP_WORD - 1) / MAP_WORD;
  localparam int WAW   = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(PAGES);
  localparam int CW    = $clog2(PAGES + 1);
  localparam int DW    = CW + 1;

  localparam int T0    = PAGES < CFG_TOTAL_RST ? PAGES : CFG_TOTAL_RST;
  localparam int R0    = CFG_RESERVED_RST < T0 ? CFG_RESERVED_RST : T0;
  localparam int HINT0 = (R0 + 1 < T0) ? R0 + 1 : 0;

  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HCHK  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MARK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // offset of page a inside the word at base b, held to 0..MAP_WORD
  function automatic logic [SW-1:0] off_clamp(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [DW-1:0] d;
    d = a - b;
    if (a <= b) begin
      return '0;
    end else if (d >= DW'(MAP_WORD)) begin
      return SW'(MAP_WORD);
    end else begin
      return d[SW-1:0];
    end
  endfunction

  function automatic logic [MAP_WORD-1:0] low_ones(logic [SW-1:0] n);
    return ~({MAP_WORD{1'b1}} << n);
  endfunction

  // index of lowest set bit, MAP_WORD when none
  function automatic logic [SW-1:0] lsb_index(logic [MAP_WORD-1:0] v);
    logic [SW-1:0] idx;
    idx = SW'(MAP_WORD);
    for (int i = MAP_WORD - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [MAP_WORD-1:0] reverse(logic [MAP_WORD-1:0] v);
    logic [MAP_WORD-1:0] r;
    for (int i = 0; i < MAP_WORD; i++) begin
      r[i] = v[MAP_WORD-1-i];
    end
    return r;
  endfunction

  function automatic logic [WAW-1:0] word_of(logic [CW-1:0] p);
    return WAW'(p >> LW);
  endfunction

  function automatic logic [CW-1:0] base_of(logic [WAW-1:0] a);
    return CW'({a, {LW{1'b0}}});
  endfunction

  logic [2:0]          state;
  logic [WAW-1:0]      rd_addr;
  logic [WAW-1:0]      rd_end;
  logic                rd_on;
  logic                p1_v;
  logic [WAW-1:0]      p1_addr;
  logic                p1_last;
  logic                p2_v;
  logic [WAW-1:0]      p2_addr;
  logic                p2_last;
  logic [MAP_WORD-1:0] e_reg;
  logic [CW-1:0]       c_run;
  logic [CW-1:0]       rs;
  logic [CW-1:0]       len_r;
  logic [CW-1:0]       from_r;
  logic [CW-1:0]       mark_lo;
  logic [CW-1:0]       mark_hi;
  logic [PW-1:0]       tgt;
  logic [CMD_W-1:0]    kind;
  logic [CW-1:0]       init_r;
  logic                report;
  logic [PW-1:0]       hint;
  logic [CW-1:0]       used;
  logic [PW-1:0]       start_r;
  logic                ok_r;

  logic                we;
  logic [WAW-1:0]      waddr;
  logic [MAP_WORD-1:0] wdata;
  logic [WAW-1:0]      raddr;
  logic [MAP_WORD-1:0] rdata;

  bpa_ram #(
    .WIDTH (MAP_WORD),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // command decode
  logic            hint_ok;
  logic [CW-1:0]   from_sel;
  logic            len_in_ok;
  logic            pidx_ok;
  logic [PW-1:0]   pidx;
  logic [PW-1:0]   hint_init;
  logic            bitv;
  logic [MAP_WORD-1:0] tgt_hot;

  assign hint_ok   = (hint != '0) && (CW'(hint) < eff_total);
  assign from_sel  = (CW'(hint) < eff_total) ? CW'(hint) : '0;
  assign len_in_ok = (cmd.run_length != '0) &&
                     ({17'd0, cmd.run_length} <= 32'(eff_total));
  assign pidx_ok   = {18'd0, cmd.page_index} < 32'(eff_total);
  assign pidx      = PW'(cmd.page_index);
  assign hint_init = (DW'(eff_reserved) + DW'(1) < DW'(eff_total)) ?
                     PW'(eff_reserved + CW'(1)) : '0;
  assign tgt_hot   = MAP_WORD'(1) << tgt[LW-1:0];
  assign bitv      = rdata[tgt[LW-1:0]];

  // stage 1: word just read, masked to the pages in range
  logic [CW-1:0]       base1;
  logic [MAP_WORD-1:0] e_next;
  logic [MAP_WORD-1:0] mark_mask;

  assign base1     = base_of(p1_addr);
  assign e_next    = ~rdata & ~low_ones(off_clamp(DW'(from_r), DW'(base1)))
                            & low_ones(off_clamp(DW'(eff_total), DW'(base1)));
  assign mark_mask = ~low_ones(off_clamp(DW'(mark_lo), DW'(base1)))
                   & low_ones(off_clamp(DW'(mark_hi) + DW'(1), DW'(base1)));

  // stage 2: run search over one free mask
  logic [CW-1:0]       base2;
  logic [MAP_WORD-1:0] pk [SW];
  logic [MAP_WORD-1:0] acc;
  logic [SW-1:0]       lz;
  logic [SW-1:0]       lt;
  logic                all_free;
  logic                hit_a;
  logic                hit_b;
  logic                hit;
  logic [SW-1:0]       b_idx;
  logic [LW-1:0]       a_idx;
  logic [CW-1:0]       hit_pos;
  logic [CW-1:0]       start_hit;

  always_comb begin
    pk[0] = e_reg;
    for (int j = 0; j < LW; j++) begin
      pk[j+1] = pk[j] & (pk[j] << (1 << j));
    end
    // pk[j][i]: at least 2**j free pages end at bit i
    acc = '1;
    for (int j = 0; j <= LW; j++) begin
      if (len_r[j]) begin
        acc = acc & (pk[j] << (len_r[SW-1:0] & SW'((1 << j) - 1)));
      end
    end
  end

  assign base2     = base_of(p2_addr);
  assign lz        = lsb_index(~e_reg);
  assign lt        = lsb_index(~reverse(e_reg));
  assign all_free  = &e_reg;
  // run carried in from lower words finishes in the leading free bits
  assign hit_a     = DW'(c_run) + DW'(lz) >= DW'(len_r);
  assign a_idx     = LW'(len_r - c_run - CW'(1));
  assign b_idx     = lsb_index(acc);
  assign hit_b     = (len_r <= CW'(MAP_WORD)) && (b_idx != SW'(MAP_WORD));
  assign hit       = hit_a || hit_b;
  assign hit_pos   = base2 + (hit_a ? CW'(a_idx) : CW'(b_idx[LW-1:0]));
  assign start_hit = hit_a ? rs : hit_pos - len_r + CW'(1);

  logic          scan_go;
  logic [CW-1:0] scan_from;

  assign scan_go = (state == S_IDLE && cmd_valid &&
                    ((cmd.command == CMD_ALLOC_ONE && !hint_ok && eff_total != '0) ||
                     (cmd.command == CMD_ALLOC_RUN && len_in_ok))) ||
                   (state == S_HCHK && bitv);
  assign scan_from = (state == S_IDLE && cmd.command == CMD_ALLOC_RUN) ? from_sel : '0;

  always_comb begin
    raddr = rd_addr;
    if (state == S_IDLE) begin
      raddr = (cmd.command == CMD_FREE) ? word_of(CW'(pidx)) : word_of(CW'(hint));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = word_of(CW'(tgt));
    wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = rd_addr;
        wdata = low_ones(off_clamp(DW'(init_r), DW'(base_of(rd_addr))));
      end
      S_HCHK: begin
        we    = !bitv;
        wdata = rdata | tgt_hot;
      end
      S_FCHK: begin
        we    = bitv;
        wdata = rdata & ~tgt_hot;
      end
      S_MARK: begin
        we    = p1_v;
        waddr = p1_addr;
        wdata = rdata | mark_mask;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  function automatic logic [PW-1:0] hint_after(logic [CW-1:0] p, logic [CW-1:0] t);
    return (DW'(p) + DW'(1) < DW'(t)) ? PW'(p + CW'(1)) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      rd_addr <= '0;
      rd_on   <= 1'b0;
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
      init_r  <= '0;
      report  <= 1'b0;
      hint    <= PW'(HINT0);
      used    <= '0;
      ok_r    <= 1'b0;
      start_r <= '0;
    end else begin
      // read pipeline shared by the scan and the marking sweep
      p1_v    <= rd_on;
      p1_addr <= rd_addr;
      p1_last <= (rd_addr == rd_end);
      if (rd_on) begin
        if (rd_addr == rd_end) begin
          rd_on <= 1'b0;
        end else begin
          rd_addr <= rd_addr + WAW'(1);
        end
      end
      p2_v    <= p1_v && (state == S_SCAN);
      p2_addr <= p1_addr;
      p2_last <= p1_last;
      e_reg   <= e_next;

      unique case (state)
        S_CLEAR: begin
          if (rd_addr == LAST_WORD) begin
            state <= report ? S_DONE : S_IDLE;
          end else begin
            rd_addr <= rd_addr + WAW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            kind    <= cmd.command;
            start_r <= '0;
            ok_r    <= 1'b0;
            unique case (cmd.command)
              CMD_INIT: begin
                init_r  <= eff_reserved;
                rd_addr <= '0;
                report  <= 1'b1;
                used    <= eff_reserved;
                hint    <= hint_init;
                ok_r    <= 1'b1;
                state   <= S_CLEAR;
              end
              CMD_ALLOC_ONE: begin
                len_r <= CW'(1);
                if (hint_ok) begin
                  tgt   <= hint;
                  state <= S_HCHK;
                end else begin
                  hint  <= '0;
                  state <= S_DONE;
                end
              end
              CMD_ALLOC_RUN: begin
                len_r <= CW'(cmd.run_length);
                state <= S_DONE;
              end
              CMD_FREE: begin
                tgt   <= pidx;
                state <= pidx_ok ? S_FCHK : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_HCHK: begin
          if (!bitv) begin
            start_r <= tgt;
            used    <= used + CW'(1);
            hint    <= hint_after(CW'(tgt), eff_total);
            ok_r    <= 1'b1;
            state   <= S_DONE;
          end else begin
            hint <= '0;
          end
        end
        S_FCHK: begin
          if (bitv) begin
            if (used != '0) begin
              used <= used - CW'(1);
            end
            ok_r <= 1'b1;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (p2_v) begin
            if (hit) begin
              mark_lo <= start_hit;
              mark_hi <= hit_pos;
              start_r <= PW'(start_hit);
              ok_r    <= 1'b1;
              used    <= used + len_r;
              if (kind == CMD_ALLOC_RUN) begin
                hint <= hint_after(hit_pos, eff_total);
              end
              rd_addr <= word_of(start_hit);
              rd_end  <= word_of(hit_pos);
              rd_on   <= 1'b1;
              p1_v    <= 1'b0;
              p2_v    <= 1'b0;
              state   <= S_MARK;
            end else if (p2_last) begin
              rd_on <= 1'b0;
              p1_v  <= 1'b0;
              state <= S_DONE;
            end else if (all_free) begin
              c_run <= c_run + CW'(MAP_WORD);
            end else begin
              c_run <= CW'(lt);
              rs    <= CW'(DW'(base2) + DW'(MAP_WORD) - DW'(lt));
            end
          end
        end
        S_MARK: begin
          if (p1_v && p1_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (scan_go) begin
        rd_addr <= word_of(scan_from);
        rd_end  <= word_of(eff_total - CW'(1));
        rd_on   <= 1'b1;
        p1_v    <= 1'b0;
        p2_v    <= 1'b0;
        c_run   <= '0;
        rs      <= scan_from;
        from_r  <= scan_from;
        state   <= S_SCAN;
      end
    end
  end

  assign cmd_ready      = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.start_page = PAGE_W'(start_r);
  assign res.success    = ok_r;
  assign res.used_count = COUNT_W'(used);

endmodule

>>> sv/bitmap_page_allocator_top.sv
`timescale 1ns / 1ps
// channel  handshake             payload
// cmd      cmd_valid/cmd_ready   command, page_index, run_length
// rsp      rsp_valid/rsp_ready   start_page, success, used_count
// apb      psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// One item at a time; W = ceil(PAGES/MAP_WORD) map words in one map memory
// with a read and a write port. Free and alloc-one with a free hint page
// check and update one map word; Init rewrites all W words. Alloc scans
// read one word a cycle, then mark a found run. After reset a pass clears
// the map with cmd_ready low. A full rsp register holds the engine in its
// result state; the next item is still taken once the engine hands it over.

module bitmap_page_allocator_top #(
  parameter int PAGES    = bpa_pkg::DEF_PAGES,
  parameter int MAP_WORD = bpa_pkg::DEF_MAP_WORD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [bpa_pkg::CMD_W-1:0]    command,
  input  logic [bpa_pkg::PAGE_W-1:0]   page_index,
  input  logic [bpa_pkg::COUNT_W-1:0]  run_length,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [bpa_pkg::PAGE_W-1:0]   start_page,
  output logic                         success,
  output logic [bpa_pkg::COUNT_W-1:0]  used_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import bpa_pkg::*;

  localparam int CW = $clog2(PAGES + 1);

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  logic [COUNT_W-1:0] total_pages;
  logic [COUNT_W-1:0] reserved_pages;
  logic [CW-1:0]      eff_total;
  logic [CW-1:0]      eff_reserved;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages    <= COUNT_W'(CFG_TOTAL_RST);
      reserved_pages <= COUNT_W'(CFG_RESERVED_RST);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TOTAL:    total_pages    <= pwdata[COUNT_W-1:0];
        REG_RESERVED: reserved_pages <= pwdata[COUNT_W-1:0];
        default:      total_pages    <= total_pages;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL:    prdata = {17'd0, total_pages};
      REG_RESERVED: prdata = {17'd0, reserved_pages};
      default:      prdata = '0;
    endcase
  end

  // page count capped at the map size, reserved count capped at that
  assign eff_total    = ({17'd0, total_pages} > 32'(PAGES)) ? CW'(PAGES) : CW'(total_pages);
  assign eff_reserved = ({17'd0, reserved_pages} > 32'(eff_total)) ?
                        eff_total : CW'(reserved_pages);

  cmd_t cmd;
  res_t res;
  logic eng_res_valid;
  logic eng_res_ready;

  assign cmd.command    = command;
  assign cmd.page_index = page_index;
  assign cmd.run_length = run_length;

  bpa_engine #(
    .PAGES    (PAGES),
    .MAP_WORD (MAP_WORD)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .res_valid    (eng_res_valid),
    .res_ready    (eng_res_ready),
    .res          (res),
    .eff_total    (eff_total),
    .eff_reserved (eff_reserved)
  );

  assign eng_res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_res_ready) begin
      rsp_valid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      start_page <= res.start_page;
      success    <= res.success;
      used_count <= res.used_count;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("engine took a second item while busy");

  a_result_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(eng_res_valid && cmd_ready))
    else $error("engine result and idle at once");

  a_fail_zero_page: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !success |-> start_page == '0)
    else $error("failed item reports a nonzero page");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    eng_res_valid |-> {17'd0, res.used_count} <= 32'(PAGES))
    else $error("used page count above map size");
`endif

endmodule

>>> tb/bitmap_page_allocator_top_test.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int unsigned REG_TOTAL_PAGES    = 0;
  localparam int unsigned REG_RESERVED_PAGES = 1;
  localparam int unsigned IDLE_LIMIT         = 4000;
  localparam int unsigned HOLD_CYCLES        = 300;
  localparam int unsigned PH_N               = 10;

  // Shadow copy of the allocator: map, hint, used count and both registers.
  class page_map_shadow;
    bit          page_used[DEF_PAGES];
    int unsigned hint;
    int unsigned used_pages;
    int unsigned total_reg;
    int unsigned reserved_reg;
    res_t        due_results[$];
    int unsigned mismatches;

    function new();
      total_reg    = CFG_TOTAL_RST;
      reserved_reg = CFG_RESERVED_RST;
      used_pages   = 0;
      mismatches   = 0;
      hint         = hint_past_reserved();
    endfunction

    function int unsigned page_limit();
      return (total_reg > DEF_PAGES) ? DEF_PAGES : total_reg;
    endfunction

    function int unsigned hint_past_reserved();
      int unsigned t;
      int unsigned r;
      t = page_limit();
      r = (reserved_reg > t) ? t : reserved_reg;
      return (r + 1 < t) ? r + 1 : 0;
    endfunction

    function void set_register(int unsigned idx, int unsigned value);
      if (idx == REG_TOTAL_PAGES) total_reg = value & 32'h7FFF;
      else if (idx == REG_RESERVED_PAGES) reserved_reg = value & 32'h7FFF;
    endfunction

    function void note_command(cmd_t c);
      int unsigned t;
      int unsigned r;
      int unsigned start;
      int unsigned from;
      int unsigned run;
      int unsigned rs;
      int unsigned len;
      bit          ok;
      res_t        want;
      t     = page_limit();
      start = 0;
      ok    = 0;
      len   = c.run_length;
      case (c.command)
        CMD_INIT: begin
          r = (reserved_reg > t) ? t : reserved_reg;
          foreach (page_used[i]) page_used[i] = (i < r);
          used_pages = r;
          hint = hint_past_reserved();
          ok = 1;
        end
        CMD_ALLOC_ONE: begin
          if (hint != 0 && hint < t && !page_used[hint]) begin
            start = hint;
            page_used[start] = 1;
            used_pages++;
            hint = (start + 1 < t) ? start + 1 : 0;
            ok = 1;
          end else begin
            // hint dropped; lowest free page wins and the hint stays cleared
            hint = 0;
            for (int unsigned i = 0; i < t; i++) begin
              if (!page_used[i]) begin
                start = i;
                page_used[i] = 1;
                used_pages++;
                ok = 1;
                break;
              end
            end
          end
        end
        CMD_ALLOC_RUN: begin
          if (len != 0 && len <= t) begin
            from = (hint < t) ? hint : 0;
            run  = 0;
            rs   = from;
            for (int unsigned i = from; i < t; i++) begin
              if (page_used[i]) begin
                run = 0;
                rs  = i + 1;
              end else begin
                run++;
                if (run == len) begin
                  for (int unsigned k = rs; k <= i; k++) page_used[k] = 1;
                  used_pages += len;
                  start = rs;
                  hint = (i + 1 < t) ? i + 1 : 0;
                  ok = 1;
                  break;
                end
              end
            end
          end
        end
        default: begin
          if (c.page_index < t && page_used[c.page_index]) begin
            page_used[c.page_index] = 0;
            if (used_pages > 0) used_pages--;
            ok = 1;
          end
        end
      endcase
      want.start_page = ok ? PAGE_W'(start) : '0;
      want.success    = ok;
      want.used_count = COUNT_W'(used_pages);
      due_results.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result start_page %0d success %0d used_count %0d",
                 $time, got.start_page, got.success, got.used_count);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.start_page !== want.start_page) begin
        $display("%0t: start_page expected %0d actual %0d",
                 $time, want.start_page, got.start_page);
        mismatches++;
      end
      if (got.success !== want.success) begin
        $display("%0t: success expected %0d actual %0d", $time, want.success, got.success);
        mismatches++;
      end
      if (got.used_count !== want.used_count) begin
        $display("%0t: used_count expected %0d actual %0d",
                 $time, want.used_count, got.used_count);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst        = 1'b1;
  logic               cmd_valid  = 1'b0;
  logic               cmd_ready;
  logic [CMD_W-1:0]   command    = CMD_INIT;
  logic [PAGE_W-1:0]  page_index = '0;
  logic [COUNT_W-1:0] run_length = '0;
  logic               rsp_valid;
  logic               rsp_ready  = 1'b0;
  logic [PAGE_W-1:0]  start_page;
  logic               success;
  logic [COUNT_W-1:0] used_count;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;

  page_map_shadow shadow = new();
  bit             steady = 1'b0;
  int unsigned    idle_cycles = 0;

  bitmap_page_allocator_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (steady || d < 55) return 0;
    if (d < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PAGE_W-1:0] any_page();
    return PAGE_W'($urandom);
  endfunction

  function automatic logic [COUNT_W-1:0] any_len();
    return COUNT_W'($urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(logic [CMD_W-1:0] c, logic [PAGE_W-1:0] idx,
                       logic [COUNT_W-1:0] len);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= c;
    page_index <= idx;
    run_length <= len;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(int unsigned idx, int unsigned value);
    logic [31:0] want;
    want = value & 32'h7FFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx, want, prdata);
      shadow.mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    shadow.set_register(idx, value);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned        t;
    int unsigned        lim;
    int unsigned        d;
    logic [CMD_W-1:0]   c;
    logic [PAGE_W-1:0]  idx;
    logic [COUNT_W-1:0] len;
    repeat (n) begin
      t   = shadow.page_limit();
      lim = (shadow.used_pages + 16 < t) ? shadow.used_pages + 16 : t;
      if (lim == 0) lim = 1;
      d = $urandom_range(0, 99);
      c = (d < 4) ? CMD_INIT : (d < 40) ? CMD_ALLOC_ONE : (d < 70) ? CMD_ALLOC_RUN : CMD_FREE;
      idx = any_page();
      len = any_len();
      // frees mostly land among the low pages, where the used ones cluster
      if (c == CMD_FREE && $urandom_range(0, 4) != 0) idx = $urandom_range(0, lim - 1);
      if (c == CMD_ALLOC_RUN) begin
        d = $urandom_range(0, 99);
        if (d < 5) len = '0;
        else if (d < 75) len = $urandom_range(1, 8);
        else if (d < 90 && t > 0) len = $urandom_range(1, t);
      end
      issue(c, idx, len);
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          held;
    stall = 0;
    taken = 0;
    held  = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        taken++;
        if (!held && taken >= 40) begin
          stall = HOLD_CYCLES;
          held  = 1;
        end else begin
          stall = pick_gap();
        end
      end
      @(negedge clk);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cmd_t item;
    res_t res;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        item.command    = command;
        item.page_index = page_index;
        item.run_length = run_length;
        shadow.note_command(item);
      end
      if (rsp_valid && rsp_ready) begin
        res.start_page = start_page;
        res.success    = success;
        res.used_count = used_count;
        shadow.check_result(res);
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned ph_total[PH_N]    = '{16384, 100, 64, 20, 0, 8, 32767, 300, 1, 16384};
    int unsigned ph_reserved[PH_N] = '{0, 5, 3, 0, 0, 20, 32767, 1, 0, 1};
    int unsigned ph_items[PH_N]    = '{60, 40, 50, 50, 15, 20, 25, 60, 15, 40};
    bit          ph_init[PH_N]     = '{1, 0, 1, 1, 1, 1, 1, 1, 1, 1};
    bit          ph_steady[PH_N]   = '{0, 0, 1, 0, 0, 0, 0, 1, 0, 0};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, map still clear from the post-reset pass
    issue(CMD_ALLOC_ONE, any_page(), any_len());   // takes the reset hint
    issue(CMD_ALLOC_ONE, any_page(), any_len());
    issue(CMD_FREE, 14'd2, any_len());
    issue(CMD_FREE, 14'd2, any_len());             // already free
    issue(CMD_FREE, 14'h3FFF, any_len());
    issue(CMD_ALLOC_RUN, any_page(), 15'd0);
    issue(CMD_ALLOC_RUN, any_page(), 15'd16384);   // no room above the hint
    issue(CMD_ALLOC_RUN, any_page(), 15'h7FFF);
    issue(CMD_ALLOC_RUN, any_page(), 15'd3);
    issue(CMD_INIT, any_page(), any_len());
    issue(CMD_FREE, 14'd0, any_len());             // reserved page
    issue(CMD_ALLOC_ONE, any_page(), any_len());
    wait_drained();

    // eight pages: walk the hint off the end, onto a used page, then fill up
    write_reg(REG_TOTAL_PAGES, 8);
    write_reg(REG_RESERVED_PAGES, 1);
    issue(CMD_INIT, any_page(), any_len());
    repeat (6) issue(CMD_ALLOC_ONE, any_page(), any_len());
    issue(CMD_FREE, 14'd1, any_len());
    issue(CMD_ALLOC_RUN, any_page(), 15'd1);       // scans from 0, hint lands on page 2
    issue(CMD_FREE, 14'd5, any_len());
    issue(CMD_ALLOC_ONE, any_page(), any_len());   // hint page used, rescan
    issue(CMD_ALLOC_ONE, any_page(), any_len());   // map full
    issue(CMD_ALLOC_RUN, any_page(), 15'd1);
    issue(CMD_FREE, 14'd9, any_len());             // out of range
    wait_drained();

    for (int p = 0; p < PH_N; p++) begin
      write_reg(REG_TOTAL_PAGES, ph_total[p]);
      write_reg(REG_RESERVED_PAGES, ph_reserved[p]);
      steady = ph_steady[p];
      if (ph_init[p]) issue(CMD_INIT, any_page(), any_len());
      run_random(ph_items[p]);
      wait_drained();
    end

    steady = 1'b0;
    repeat (600) @(negedge clk);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
